[hw/rtl/dltq_pkg.sv]
// shared types and constants of the delta-list timer queue
package dltq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int XCNT_W = $clog2(MAX_RESULTS + 1);
    localparam int XIDX_W = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        OP_INSTALL = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_INSTALLED = 3'd0,
        ST_FULL      = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_EXPIRED   = 3'd3,
        ST_NOTHING   = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] delay_ms;
        logic signed [31:0] tag;
        logic [7:0]  handler_id;
        logic        periodic;
        logic [29:0] elapsed_ticks;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic signed [31:0] expired_tag;
        logic [7:0]  expired_handler;
        logic [4:0]  removed_count;
        logic [31:0] head_delay_ms;
        logic        queue_empty;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] delta;
        logic [31:0] reload;
        logic [31:0] tag;
        logic [7:0]  handler;
        logic        periodic;
    } t_entry;

    // chain command, applied by every cell in the same cycle
    typedef enum logic [1:0] {
        CC_HOLD  = 2'd0,
        CC_SHUP  = 2'd1,
        CC_SHDN  = 2'd2
    } t_chain_cmd;

    typedef struct packed {
        t_chain_cmd  cmd;
        logic [IDX_W-1:0] pos;
        logic        wr_en;
        t_entry      wr_entry;
        logic        adj_en;
        logic [IDX_W-1:0] adj_pos;
        logic [31:0] adj_delta;
    } t_chain_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SCAN,
        S_INS_PUT,
        S_INS_FIX,
        S_REM_SCAN,
        S_ADV_SCAN,
        S_ADV_HEAD,
        S_RE_START,
        S_RE_SCAN,
        S_RE_PUT,
        S_RE_FIX,
        S_EMIT
    } t_state;

endpackage

[hw/rtl/dltq_cell.sv]
// one queue slot: holds an entry and shifts it to or from its neighbors
module dltq_cell (
    input  logic                  i_clk,
    input  dltq_pkg::t_chain_ctl  i_ctl,
    input  logic [dltq_pkg::IDX_W-1:0] i_idx,
    input  dltq_pkg::t_entry      i_from_lo,
    input  dltq_pkg::t_entry      i_from_hi,
    output dltq_pkg::t_entry      o_entry
);
    import dltq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.cmd)
            CC_SHUP: if (i_idx > i_ctl.pos) n_entry = i_from_lo;
            CC_SHDN: if (i_idx >= i_ctl.pos) n_entry = i_from_hi;
            default: ;
        endcase
        if (i_ctl.wr_en && i_idx == i_ctl.pos) n_entry = i_ctl.wr_entry;
        if (i_ctl.adj_en && i_idx == i_ctl.adj_pos) n_entry.delta = i_ctl.adj_delta;
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
endmodule

[hw/rtl/dltq_chain.sv]
// row of slots linked to their neighbors
module dltq_chain (
    input  logic                 i_clk,
    input  dltq_pkg::t_chain_ctl i_ctl,
    output dltq_pkg::t_entry     o_slot [dltq_pkg::QUEUE_DEPTH]
);
    import dltq_pkg::*;

    t_entry w_slot [QUEUE_DEPTH];

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        dltq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl),
            .i_idx     (IDX_W'(g)),
            .i_from_lo (w_slot[(g == 0) ? 0 : g - 1]),
            .i_from_hi (w_slot[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
            .o_entry   (w_slot[g])
        );
    end

    assign o_slot = w_slot;
endmodule

[hw/rtl/delta_list_timer_queue.sv]
// top level: sequencer over the slot chain with a result buffer
// install: scan for the slot, write the entry, then fix its successor's delta; remove: scan and
//   shift out every match; advance: pop expired heads, trim the head delta, then reinsert periodic entries
// throughput: one request at a time, next accepted after its last result is taken
// the sort scan walks the chain one slot a cycle; results are then sent one a cycle while i_ready is high
// reset: synchronous active low, empties the queue; slot contents are not cleared
module delta_list_timer_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  dltq_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output dltq_pkg::t_out_item o_data
);
    import dltq_pkg::*;

    t_state r_state, n_state;
    t_in_item r_req, n_req;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W:0] r_i, n_i;
    logic [32:0] r_rem, n_rem;
    logic [34:0] r_el, n_el;
    logic [4:0] r_removed, n_removed;
    logic [XCNT_W-1:0] r_xcnt, n_xcnt;
    logic [XCNT_W-1:0] r_k, n_k;
    t_status r_status, n_status;
    logic [31:0] r_xtag [MAX_RESULTS];
    logic [7:0]  r_xhdl [MAX_RESULTS];
    logic [31:0] r_xrel [MAX_RESULTS];
    logic        r_xper [MAX_RESULTS];
    logic        x_we;
    t_chain_ctl  w_ctl;
    t_entry      w_slot [QUEUE_DEPTH];
    t_entry      w_cur, w_head;
    t_entry      r_ins, n_ins;
    logic        w_scan_ok;

    dltq_chain u_chain (.i_clk(i_clk), .i_ctl(w_ctl), .o_slot(w_slot));

    assign w_cur  = w_slot[r_i[IDX_W-1:0]];
    assign w_head = w_slot[0];
    assign w_scan_ok = (r_i < (IDX_W+1)'(r_count));

    always_comb begin
        n_state = r_state; n_req = r_req; n_count = r_count; n_i = r_i;
        n_rem = r_rem; n_el = r_el; n_removed = r_removed; n_xcnt = r_xcnt;
        n_k = r_k; n_status = r_status; n_ins = r_ins;
        x_we = 1'b0;
        w_ctl = '0;
        w_ctl.cmd = CC_HOLD;
        o_ready = 1'b0;
        o_valid = 1'b0;
        o_data = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_req = i_data;
                    n_i = '0;
                    n_k = '0;
                    n_xcnt = '0;
                    n_removed = '0;
                    case (t_op'(i_data.operation))
                        OP_INSTALL: begin
                            if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                n_status = ST_FULL;
                                n_state = S_EMIT;
                            end else begin
                                n_ins = '{delta: 32'd0, reload: i_data.delay_ms,
                                    tag: i_data.tag, handler: i_data.handler_id,
                                    periodic: i_data.periodic};
                                n_rem = {1'b0, i_data.delay_ms};
                                n_status = ST_INSTALLED;
                                n_state = S_INS_SCAN;
                            end
                        end
                        OP_REMOVE: begin
                            n_status = ST_REMOVED;
                            n_state = S_REM_SCAN;
                        end
                        OP_ADVANCE: begin
                            n_el = 35'(i_data.elapsed_ticks) * 35'd5;
                            n_status = ST_NOTHING;
                            n_state = S_ADV_SCAN;
                        end
                        default: begin
                            n_status = ST_NOTHING;
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_INS_SCAN, S_RE_SCAN: begin
                if (w_scan_ok && {1'b0, w_cur.delta} <= r_rem) begin
                    n_rem = r_rem - {1'b0, w_cur.delta};
                    n_i = r_i + 1'b1;
                end else begin
                    n_state = (r_state == S_INS_SCAN) ? S_INS_PUT : S_RE_PUT;
                end
            end
            S_INS_PUT, S_RE_PUT: begin
                w_ctl.cmd = CC_SHUP;
                w_ctl.pos = r_i[IDX_W-1:0];
                w_ctl.wr_en = 1'b1;
                w_ctl.wr_entry = r_ins;
                w_ctl.wr_entry.delta = r_rem[31:0];
                n_count = r_count + 1'b1;
                n_state = (r_state == S_INS_PUT) ? S_INS_FIX : S_RE_FIX;
            end
            S_INS_FIX, S_RE_FIX: begin
                if (r_i + 1'b1 < (IDX_W+1)'(r_count)) begin
                    w_ctl.adj_en = 1'b1;
                    w_ctl.adj_pos = IDX_W'(r_i + 1'b1);
                    w_ctl.adj_delta = w_slot[IDX_W'(r_i + 1'b1)].delta - r_rem[31:0];
                end
                if (r_state == S_INS_FIX) begin
                    n_state = S_EMIT;
                end else begin
                    n_k = r_k + 1'b1;
                    n_state = S_RE_START;
                end
            end
            S_REM_SCAN: begin
                if (!w_scan_ok) begin
                    n_state = S_EMIT;
                end else if (w_cur.tag == r_req.tag && w_cur.handler == r_req.handler_id) begin
                    w_ctl.cmd = CC_SHDN;
                    w_ctl.pos = r_i[IDX_W-1:0];
                    if (r_i + 1'b1 < (IDX_W+1)'(r_count)) begin
                        // successor lands at the removed slot
                        w_ctl.adj_en = 1'b1;
                        w_ctl.adj_pos = r_i[IDX_W-1:0];
                        w_ctl.adj_delta = ({1'b0, w_slot[IDX_W'(r_i + 1'b1)].delta}
                            + {1'b0, w_cur.delta} > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF :
                            w_slot[IDX_W'(r_i + 1'b1)].delta + w_cur.delta;
                    end
                    n_count = r_count - 1'b1;
                    if (r_removed != 5'd31) n_removed = r_removed + 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_ADV_SCAN: begin
                if (r_count != '0 && r_xcnt != XCNT_W'(MAX_RESULTS)
                        && {3'b0, w_head.delta} <= r_el) begin
                    n_el = r_el - {3'b0, w_head.delta};
                    x_we = 1'b1;
                    w_ctl.cmd = CC_SHDN;
                    w_ctl.pos = '0;
                    n_count = r_count - 1'b1;
                    n_xcnt = r_xcnt + 1'b1;
                    n_status = ST_EXPIRED;
                end else begin
                    n_state = S_ADV_HEAD;
                end
            end
            S_ADV_HEAD: begin
                if (r_count != '0) begin
                    w_ctl.adj_en = 1'b1;
                    w_ctl.adj_pos = '0;
                    w_ctl.adj_delta = ({3'b0, w_head.delta} > r_el) ?
                        w_head.delta - r_el[31:0] : 32'd0;
                end
                n_k = '0;
                n_state = S_RE_START;
            end
            S_RE_START: begin
                if (r_k == r_xcnt) begin
                    n_k = '0;
                    n_state = S_EMIT;
                end else if (r_xper[XIDX_W'(r_k)] && r_count != CNT_W'(QUEUE_DEPTH)) begin
                    n_ins = '{delta: 32'd0, reload: r_xrel[XIDX_W'(r_k)],
                        tag: r_xtag[XIDX_W'(r_k)], handler: r_xhdl[XIDX_W'(r_k)],
                        periodic: 1'b1};
                    n_rem = {1'b0, r_xrel[XIDX_W'(r_k)]};
                    n_i = '0;
                    n_state = S_RE_SCAN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_EMIT: begin
                o_valid = 1'b1;
                o_data.status = r_status;
                if (r_status == ST_EXPIRED) begin
                    o_data.expired_tag = r_xtag[XIDX_W'(r_k)];
                    o_data.expired_handler = r_xhdl[XIDX_W'(r_k)];
                end
                if (r_status == ST_REMOVED) o_data.removed_count = r_removed;
                o_data.head_delay_ms = (r_count != '0) ? w_head.delta : 32'd0;
                o_data.queue_empty = (r_count == '0);
                o_data.last = (r_status != ST_EXPIRED) || (r_k + 1'b1 == r_xcnt);
                if (i_ready) begin
                    if (o_data.last) n_state = S_IDLE;
                    else n_k = r_k + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_req <= n_req; r_i <= n_i; r_rem <= n_rem; r_el <= n_el;
        r_removed <= n_removed; r_xcnt <= n_xcnt; r_k <= n_k; r_status <= n_status;
        r_ins <= n_ins;
        if (x_we) begin
            r_xtag[XIDX_W'(r_xcnt)] <= w_head.tag;
            r_xhdl[XIDX_W'(r_xcnt)] <= w_head.handler;
            r_xrel[XIDX_W'(r_xcnt)] <= w_head.reload;
            r_xper[XIDX_W'(r_xcnt)] <= w_head.periodic;
        end
    end
endmodule

[hw/rtl/dltq_checker.sv]
// port-level checks of the timer queue, bound to the top level
module dltq_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input dltq_pkg::t_out_item o_data
);
    import dltq_pkg::*;

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.queue_empty |-> o_data.head_delay_ms == 32'd0)
        else $error("empty queue with nonzero head delay");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("request taken while a result is pending");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready again right after a request was taken");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status <= 3'd4)
        else $error("status code out of range");
endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);
